/* hw/rtl/sws_pkg.sv */
// ----------------------------------------------------------------------------
// sws_pkg
// Shared types, codes and the microcode program of the sliding window sender.
// ----------------------------------------------------------------------------
`default_nettype none

package sws_pkg;

  // Input opcodes.
  localparam logic [1:0] OPC_BEGIN = 2'd0;
  localparam logic [1:0] OPC_ACK   = 2'd1;
  localparam logic [1:0] OPC_TICK  = 2'd2;

  // Header type of a received acknowledgement.
  localparam logic [1:0] HDR_ACK = 2'd3;

  // Kinds of result transactions.
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_DATA  = 2'd2;
  localparam logic [1:0] KIND_DONE  = 2'd3;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_MAX_INFLIGHT  = 2'd0;
  localparam logic [1:0] REG_PACKET_COUNT  = 2'd1;
  localparam logic [1:0] REG_SESSION_SEQ   = 2'd2;
  localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd3;

  // Register reset values.
  localparam logic [6:0]  MAX_INFLIGHT_RST  = 7'd8;
  localparam logic [19:0] TIMEOUT_TICKS_RST = 20'd500000;

  // Width of the microcode step counter.
  localparam int STEP_W = 6;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_START = 5'b00010,
    PH_DATA  = 5'b00100,
    PH_END   = 5'b01000,
    PH_DONE  = 5'b10000
  } phase_t;

  // Datapath operations selected by a control word.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_BEGIN,
    OP_CLR_EL,
    OP_EMIT,
    OP_LOAD_WIN,
    OP_CALC_NB,
    OP_CALC_NL,
    OP_CLAMP_HI,
    OP_CLAMP_LO,
    OP_ADVANCE,
    OP_TICK_INC,
    OP_SEND
  } op_t;

  // Jump conditions.
  typedef enum logic [4:0] {
    C_NEVER,
    C_ALWAYS,
    C_IN,
    C_OP_ACK,
    C_OP_TICK,
    C_OP_NOT_BEGIN,
    C_ACK_BAD,
    C_PH_DATA,
    C_PH_END,
    C_PH_NOT_START,
    C_BASE_LT_PC,
    C_SEQ_SKIP,
    C_NB_LE_BASE,
    C_NB_LT_PC,
    C_SEQ_NE_SESS,
    C_NOT_WAITING,
    C_EL_LT_LIM,
    C_CUR_GE_STOP,
    C_LAST
  } cond_t;

  typedef struct packed {
    op_t        op;
    cond_t      cond;
    step_t      target;
    logic       hold;    // stay on this step while the condition is false
    logic       set_ph;
    phase_t     ph;
    logic [1:0] kind;
  } ctrl_t;

  // Status flags from the datapath that the jump conditions test.
  typedef struct packed {
    logic in_valid;
    logic op_ack;
    logic op_tick;
    logic op_not_begin;
    logic ack_bad;
    logic ph_data;
    logic ph_end;
    logic ph_not_start;
    logic base_lt_pc;
    logic seq_skip;
    logic nb_le_base;
    logic nb_lt_pc;
    logic seq_ne_sess;
    logic not_waiting;
    logic el_lt_lim;
    logic cur_ge_stop;
    logic last;
  } stat_t;

  // Program labels.
  localparam step_t S_FETCH     = 6'd0;
  localparam step_t S_ACK       = 6'd6;
  localparam step_t S_ACK_START = 6'd12;
  localparam step_t S_ACK_DATA  = 6'd13;
  localparam step_t S_ACK_END   = 6'd21;
  localparam step_t S_TICK      = 6'd23;
  localparam step_t S_TO_END    = 6'd29;
  localparam step_t S_TO_DATA   = 6'd30;
  localparam step_t S_SEND_CHK  = 6'd31;
  localparam step_t S_SEND      = 6'd32;

  function automatic ctrl_t cw(op_t op, cond_t cond, step_t target, logic hold,
                               logic set_ph, phase_t ph, logic [1:0] kind);
    ctrl_t c;
    c.op     = op;
    c.cond   = cond;
    c.target = target;
    c.hold   = hold;
    c.set_ph = set_ph;
    c.ph     = ph;
    c.kind   = kind;
    return c;
  endfunction

  // The control program, one word per step.
  function automatic ctrl_t ucode(step_t s);
    ctrl_t c;
    case (s)
      // Fetch and dispatch on the opcode.
      6'd0:  c = cw(OP_ACCEPT,   C_IN,           6'd1,        1'b1, 1'b0, PH_IDLE,  KIND_START);
      6'd1:  c = cw(OP_NONE,     C_OP_ACK,       S_ACK,       1'b0, 1'b0, PH_IDLE,  KIND_START);
      6'd2:  c = cw(OP_NONE,     C_OP_TICK,      S_TICK,      1'b0, 1'b0, PH_IDLE,  KIND_START);
      6'd3:  c = cw(OP_NONE,     C_OP_NOT_BEGIN, S_FETCH,     1'b0, 1'b0, PH_IDLE,  KIND_START);
      // Begin a transfer.
      6'd4:  c = cw(OP_BEGIN,    C_NEVER,        S_FETCH,     1'b0, 1'b1, PH_START, KIND_START);
      6'd5:  c = cw(OP_EMIT,     C_ALWAYS,       S_FETCH,     1'b0, 1'b0, PH_IDLE,  KIND_START);
      // Acknowledgement: validate and dispatch on the phase.
      6'd6:  c = cw(OP_NONE,     C_ACK_BAD,      S_FETCH,     1'b0, 1'b0, PH_IDLE,  KIND_START);
      6'd7:  c = cw(OP_NONE,     C_PH_DATA,      S_ACK_DATA,  1'b0, 1'b0, PH_IDLE,  KIND_START);
      6'd8:  c = cw(OP_NONE,     C_PH_END,       S_ACK_END,   1'b0, 1'b0, PH_IDLE,  KIND_START);
      6'd9:  c = cw(OP_NONE,     C_PH_NOT_START, S_FETCH,     1'b0, 1'b0, PH_IDLE,  KIND_START);
      // START acknowledged (the sequence check rides on the phase test above).
      6'd10: c = cw(OP_CLR_EL,   C_BASE_LT_PC,   S_ACK_START, 1'b0, 1'b0, PH_IDLE,  KIND_START);
      6'd11: c = cw(OP_EMIT,     C_ALWAYS,       S_FETCH,     1'b0, 1'b1, PH_END,   KIND_END);
      6'd12: c = cw(OP_LOAD_WIN, C_ALWAYS,       S_SEND_CHK,  1'b0, 1'b1, PH_DATA,  KIND_DATA);
      // Cumulative acknowledgement in the data phase.
      6'd13: c = cw(OP_NONE,     C_SEQ_SKIP,     S_FETCH,     1'b0, 1'b0, PH_IDLE,  KIND_DATA);
      6'd14: c = cw(OP_CALC_NB,  C_NEVER,        S_FETCH,     1'b0, 1'b0, PH_IDLE,  KIND_DATA);
      6'd15: c = cw(OP_NONE,     C_NB_LE_BASE,   S_FETCH,     1'b0, 1'b0, PH_IDLE,  KIND_DATA);
      6'd16: c = cw(OP_CALC_NL,  C_NEVER,        S_FETCH,     1'b0, 1'b0, PH_IDLE,  KIND_DATA);
      6'd17: c = cw(OP_CLAMP_HI, C_NEVER,        S_FETCH,     1'b0, 1'b0, PH_IDLE,  KIND_DATA);
      6'd18: c = cw(OP_CLAMP_LO, C_NEVER,        S_FETCH,     1'b0, 1'b0, PH_IDLE,  KIND_DATA);
      6'd19: c = cw(OP_ADVANCE,  C_NB_LT_PC,     S_SEND_CHK,  1'b0, 1'b0, PH_IDLE,  KIND_DATA);
      6'd20: c = cw(OP_EMIT,     C_ALWAYS,       S_FETCH,     1'b0, 1'b1, PH_END,   KIND_END);
      // END acknowledged.
      6'd21: c = cw(OP_NONE,     C_SEQ_NE_SESS,  S_FETCH,     1'b0, 1'b0, PH_IDLE,  KIND_DONE);
      6'd22: c = cw(OP_EMIT,     C_ALWAYS,       S_FETCH,     1'b0, 1'b1, PH_DONE,  KIND_DONE);
      // Timer tick.
      6'd23: c = cw(OP_NONE,     C_NOT_WAITING,  S_FETCH,     1'b0, 1'b0, PH_IDLE,  KIND_START);
      6'd24: c = cw(OP_TICK_INC, C_NEVER,        S_FETCH,     1'b0, 1'b0, PH_IDLE,  KIND_START);
      6'd25: c = cw(OP_NONE,     C_EL_LT_LIM,    S_FETCH,     1'b0, 1'b0, PH_IDLE,  KIND_START);
      6'd26: c = cw(OP_CLR_EL,   C_PH_DATA,      S_TO_DATA,   1'b0, 1'b0, PH_IDLE,  KIND_START);
      6'd27: c = cw(OP_NONE,     C_PH_END,       S_TO_END,    1'b0, 1'b0, PH_IDLE,  KIND_START);
      6'd28: c = cw(OP_EMIT,     C_ALWAYS,       S_FETCH,     1'b0, 1'b0, PH_IDLE,  KIND_START);
      6'd29: c = cw(OP_EMIT,     C_ALWAYS,       S_FETCH,     1'b0, 1'b0, PH_IDLE,  KIND_END);
      6'd30: c = cw(OP_LOAD_WIN, C_NEVER,        S_FETCH,     1'b0, 1'b0, PH_IDLE,  KIND_DATA);
      // Send loop: one DATA send a cycle unless stalled, to range end.
      6'd31: c = cw(OP_NONE,     C_CUR_GE_STOP,  S_FETCH,     1'b0, 1'b0, PH_IDLE,  KIND_DATA);
      6'd32: c = cw(OP_SEND,     C_LAST,         S_FETCH,     1'b1, 1'b0, PH_IDLE,  KIND_DATA);
      default: c = cw(OP_NONE,   C_ALWAYS,       S_FETCH,     1'b0, 1'b0, PH_IDLE,  KIND_START);
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/sliding_window_sender.sv */
// ----------------------------------------------------------------------------
// sliding_window_sender
// Sender controller of a sliding window reliable transfer: START handshake,
// windowed DATA phase with cumulative acks, END handshake, tick timeouts.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Transaction                 Payload
//  -------  ---  --------------------------  -----------------------------------
//  APB      in   psel&penable&pwrite write   max_inflight, packet_count,
//                                            session_seq, timeout_ticks
//  s_t*     in   s_tvalid & s_tready         opcode, ack_kind (tuser),
//                                            ack_seq, ack_check (tdata)
//  m_t*     out  m_tvalid & m_tready         send_kind (tuser), send_seq (tdata),
//                                            last (tlast)
//
// Each input transaction is worked by a microcoded sequencer, one control
// word per cycle unless a stalled emit step holds it. A DATA send run
// decodes the input and then emits one DATA transaction per cycle, up to
// a full window of 64 packets. A stalled m_tready holds the sequencer on
// its emit step; the output register lets the next input transaction be
// taken while the last result still waits. Reset is synchronous and needs
// no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_sender
  import sws_pkg::*;
#(
  parameter int MAX_WINDOW = 64
) (
  input  wire         clk,
  input  wire         rst,
  // Configuration port
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [63:0] s_tdata,   // [31:0] ack_seq, [63:32] ack_check
  input  wire  [3:0]  s_tuser,   // [1:0] opcode, [3:2] ack_kind
  // Output stream
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [31:0] m_tdata,   // [31:0] send_seq
  output logic [1:0]  m_tuser,   // [1:0] send_kind
  output logic        m_tlast
);

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);

  // Configuration registers.
  logic [6:0]  max_inflight;
  logic [31:0] packet_count;
  logic [31:0] session_seq;
  logic [19:0] timeout_ticks;

  // Transfer state.
  phase_t      phase;
  logic [31:0] window_base;
  logic [31:0] window_limit;
  logic [19:0] elapsed_ticks;

  // Latched input transaction.
  logic [1:0]  opcode;
  logic [1:0]  ack_kind;
  logic [31:0] ack_seq;
  logic [31:0] ack_check;

  // Scratch registers of the datapath.
  logic [31:0] new_base;
  logic [32:0] new_limit;
  logic [31:0] cur;
  logic [31:0] stop;
  logic [CNT_W-1:0] sent;

  // Output register.
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [31:0] out_seq;
  logic        out_last;

  ctrl_t ctrl;
  stat_t stat;
  logic  run;
  logic  emit_ok;
  logic  cfg_wr;
  logic  in_acc;
  logic  [6:0]  win_eff;
  logic  [19:0] tick_lim;

  sws_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .stat    (stat),
    .emit_ok (emit_ok),
    .ctrl    (ctrl),
    .run     (run)
  );

  // --------------------------------------------------------------------------
  // Configuration port. Registers are decoded by word address.
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_inflight  <= MAX_INFLIGHT_RST;
      packet_count  <= '0;
      session_seq   <= '0;
      timeout_ticks <= TIMEOUT_TICKS_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_MAX_INFLIGHT:  max_inflight  <= pwdata[6:0];
        REG_PACKET_COUNT:  packet_count  <= pwdata;
        REG_SESSION_SEQ:   session_seq   <= pwdata;
        REG_TIMEOUT_TICKS: timeout_ticks <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MAX_INFLIGHT:  prdata = {25'd0, max_inflight};
      REG_PACKET_COUNT:  prdata = packet_count;
      REG_SESSION_SEQ:   prdata = session_seq;
      REG_TIMEOUT_TICKS: prdata = {12'd0, timeout_ticks};
      default:           prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Status flags for the sequencer's jump conditions.
  // --------------------------------------------------------------------------
  // The window size is used clamped to one through MAX_WINDOW, and a zero
  // timeout behaves as one tick.
  always_comb begin
    if (max_inflight == 7'd0) begin
      win_eff = 7'd1;
    end else if (max_inflight > 7'(MAX_WINDOW)) begin
      win_eff = 7'(MAX_WINDOW);
    end else begin
      win_eff = max_inflight;
    end
    tick_lim = (timeout_ticks == 20'd0) ? 20'd1 : timeout_ticks;
  end

  // Nothing is taken while reset is held.
  assign s_tready = (ctrl.op == OP_ACCEPT) && !rst;
  assign in_acc   = s_tvalid && s_tready;

  always_comb begin
    stat.in_valid     = s_tvalid;
    stat.op_ack       = (opcode == OPC_ACK);
    stat.op_tick      = (opcode == OPC_TICK);
    stat.op_not_begin = (opcode != OPC_BEGIN);
    stat.ack_bad      = (ack_kind != HDR_ACK) || (ack_check != 32'd0);
    stat.ph_data      = (phase == PH_DATA);
    stat.ph_end       = (phase == PH_END);
    stat.ph_not_start = (phase != PH_START);
    stat.base_lt_pc   = (window_base < packet_count);
    stat.seq_skip     = (ack_seq == session_seq) || (ack_seq <= window_base);
    stat.nb_le_base   = (new_base <= window_base);
    stat.nb_lt_pc     = (new_base < packet_count);
    stat.seq_ne_sess  = (ack_seq != session_seq);
    stat.not_waiting  = (phase == PH_IDLE) || (phase == PH_DONE);
    stat.el_lt_lim    = (elapsed_ticks < tick_lim);
    stat.cur_ge_stop  = (cur >= stop);
    // The send loop ends on the last packet of the range, or when one input
    // transaction has produced a full window of results.
    stat.last         = ((stop - cur) == 32'd1) || (sent == CNT_W'(MAX_WINDOW - 1));
  end

  // --------------------------------------------------------------------------
  // Datapath, driven by the current control word.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      window_base   <= '0;
      window_limit  <= '0;
      elapsed_ticks <= '0;
    end else if (run) begin
      if (ctrl.set_ph) begin
        phase <= ctrl.ph;
      end
      case (ctrl.op)
        OP_BEGIN: begin
          window_base   <= '0;
          window_limit  <= (packet_count < 32'(win_eff)) ? packet_count : 32'(win_eff);
          elapsed_ticks <= '0;
        end
        OP_CLR_EL, OP_EMIT, OP_SEND, OP_CALC_NL: begin
          elapsed_ticks <= '0;
        end
        OP_TICK_INC: begin
          elapsed_ticks <= elapsed_ticks + 20'd1;
        end
        OP_ADVANCE: begin
          window_base  <= new_base;
          window_limit <= new_limit[31:0];
        end
        default: ;
      endcase
    end
  end

  // Scratch and input registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      opcode    <= s_tuser[1:0];
      ack_kind  <= s_tuser[3:2];
      ack_seq   <= s_tdata[31:0];
      ack_check <= s_tdata[63:32];
      sent      <= '0;
    end
    if (run) begin
      case (ctrl.op)
        OP_CALC_NB: begin
          new_base <= (ack_seq < packet_count) ? ack_seq : packet_count;
        end
        OP_CALC_NL: begin
          // The limit moves by as much as the base does.
          new_limit <= {1'b0, window_limit} + {1'b0, new_base - window_base};
        end
        OP_CLAMP_HI: begin
          if (new_limit > {1'b0, packet_count}) begin
            new_limit <= {1'b0, packet_count};
          end
        end
        OP_CLAMP_LO: begin
          if (new_limit < {1'b0, new_base}) begin
            new_limit <= {1'b0, new_base};
          end
        end
        OP_ADVANCE: begin
          // Only packets that newly enter the window are sent.
          cur  <= (window_limit > new_base) ? window_limit : new_base;
          stop <= new_limit[31:0];
        end
        OP_LOAD_WIN: begin
          cur  <= window_base;
          stop <= window_limit;
        end
        OP_SEND: begin
          cur  <= cur + 32'd1;
          sent <= sent + CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Output register.
  // --------------------------------------------------------------------------
  assign emit_ok = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (run && (ctrl.op == OP_EMIT || ctrl.op == OP_SEND)) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (run && ctrl.op == OP_EMIT) begin
      out_kind <= ctrl.kind;
      out_seq  <= session_seq;
      out_last <= 1'b1;
    end else if (run && ctrl.op == OP_SEND) begin
      out_kind <= KIND_DATA;
      out_seq  <= cur;
      out_last <= stat.last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_seq;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

endmodule

`default_nettype wire

/* hw/rtl/sws_seq.sv */
// ----------------------------------------------------------------------------
// sws_seq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module sws_seq
  import sws_pkg::*;
(
  input  wire   clk,
  input  wire   rst,
  input  stat_t stat,
  input  wire   emit_ok,   // output register can take a transaction
  output ctrl_t ctrl,
  output logic  run        // the current control word executes this cycle
);

  step_t step;
  step_t step_next;
  logic  cond_true;
  logic  emits;

  assign ctrl  = ucode(step);
  assign emits = (ctrl.op == OP_EMIT) || (ctrl.op == OP_SEND);
  assign run   = !(emits && !emit_ok);

  always_comb begin
    case (ctrl.cond)
      C_NEVER:        cond_true = 1'b0;
      C_ALWAYS:       cond_true = 1'b1;
      C_IN:           cond_true = stat.in_valid;
      C_OP_ACK:       cond_true = stat.op_ack;
      C_OP_TICK:      cond_true = stat.op_tick;
      C_OP_NOT_BEGIN: cond_true = stat.op_not_begin;
      C_ACK_BAD:      cond_true = stat.ack_bad;
      C_PH_DATA:      cond_true = stat.ph_data;
      C_PH_END:       cond_true = stat.ph_end;
      C_PH_NOT_START: cond_true = stat.ph_not_start || stat.seq_ne_sess;
      C_BASE_LT_PC:   cond_true = stat.base_lt_pc;
      C_SEQ_SKIP:     cond_true = stat.seq_skip;
      C_NB_LE_BASE:   cond_true = stat.nb_le_base;
      C_NB_LT_PC:     cond_true = stat.nb_lt_pc;
      C_SEQ_NE_SESS:  cond_true = stat.seq_ne_sess;
      C_NOT_WAITING:  cond_true = stat.not_waiting;
      C_EL_LT_LIM:    cond_true = stat.el_lt_lim;
      C_CUR_GE_STOP:  cond_true = stat.cur_ge_stop;
      C_LAST:         cond_true = stat.last;
      default:        cond_true = 1'b0;
    endcase
  end

  always_comb begin
    if (!run) begin
      step_next = step;
    end else if (cond_true) begin
      step_next = ctrl.target;
    end else if (ctrl.hold) begin
      step_next = step;
    end else begin
      step_next = step + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_FETCH;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

/* sim/sliding_window_sender_test.sv */
// ----------------------------------------------------------------------------
// sliding_window_sender_test
// Self-checking bench for the sliding window sender. Input transactions are
// driven on the slave stream, and each accepted one is run through a
// transfer tracker that mirrors the START, DATA and END phases and keeps the
// send commands they must cause. Every output transaction is compared with
// the oldest of those commands. Registers are set over the APB port while
// the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sliding_window_sender_test;
  import sws_pkg::*;

  // The block never emits more than a full window of commands per input.
  localparam int unsigned WINDOW_CAP = 64;
  // Opcode 3 is not assigned; the block must ignore it.
  localparam logic [1:0] OPC_UNUSED = 2'd3;
  // Pause after the last expected send; leaves the sequencer time to finish.
  localparam int unsigned SETTLE_CYCLES = 120;
  // Length of the one long receiver stall that backs the block up.
  localparam int unsigned HOLD_CYCLES = 400;
  // Random input transactions, on top of the directed ones at the start.
  localparam int unsigned RANDOM_ITEMS = 200;
  // Random input transactions between two changes of the settings.
  localparam int unsigned STRETCH_ITEMS = 40;
  // Worst case: about 230 inputs, each with 64 sends that wait out short
  // receiver stalls, plus the pauses between settings, stays well inside
  // this limit of 8 ms at 12 ns a cycle.
  localparam int unsigned RUN_LIMIT_NS = 8_000_000;

  // One expected send command: the output tuser, tdata and tlast.
  typedef struct {
    logic [1:0]  kind;
    logic [31:0] seq;
    logic        last;
  } send_rec_t;

  // Tracks one transfer the way the sender should see it and queues the
  // send commands that each accepted input transaction causes.
  class transfer_tracker;
    logic [6:0]  max_inflight;
    logic [31:0] packet_count;
    logic [31:0] session_seq;
    logic [19:0] timeout_ticks;
    phase_t      phase;
    logic [31:0] base;
    logic [31:0] limit;
    logic [19:0] elapsed;
    send_rec_t   pending[$];
    send_rec_t   batch[$];

    function new();
      max_inflight  = MAX_INFLIGHT_RST;
      packet_count  = '0;
      session_seq   = '0;
      timeout_ticks = TIMEOUT_TICKS_RST;
      phase         = PH_IDLE;
      base          = '0;
      limit         = '0;
      elapsed       = '0;
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_MAX_INFLIGHT:  max_inflight  = value[6:0];
        REG_PACKET_COUNT:  packet_count  = value;
        REG_SESSION_SEQ:   session_seq   = value;
        REG_TIMEOUT_TICKS: timeout_ticks = value[19:0];
        default: ;
      endcase
    endfunction

    // The window register is used clamped to 1..64.
    function logic [31:0] span_width();
      logic [31:0] w;
      w = {25'b0, max_inflight};
      if (w < 1) w = 1;
      if (w > WINDOW_CAP) w = WINDOW_CAP;
      return w;
    endfunction

    function void queue_send(logic [1:0] kind, logic [31:0] seq);
      if (batch.size() < WINDOW_CAP) batch.insert(batch.size(), '{kind, seq, 1'b0});
    endfunction

    function void queue_range(logic [31:0] from, logic [31:0] upto);
      logic [32:0] i;
      for (i = {1'b0, from}; i < {1'b0, upto} && batch.size() < WINDOW_CAP; i++)
        queue_send(KIND_DATA, i[31:0]);
    endfunction

    function void take_ack(logic [31:0] seq);
      logic [31:0] nb;
      logic [31:0] old_limit;
      logic [32:0] nl;
      case (phase)
        PH_START: begin
          if (seq != session_seq) return;
          elapsed = '0;
          if (base >= packet_count) begin
            // Empty transfer: straight to the END handshake.
            phase = PH_END;
            queue_send(KIND_END, session_seq);
          end else begin
            phase = PH_DATA;
            queue_range(base, limit);
          end
        end
        PH_DATA: begin
          if (seq == session_seq || seq <= base) return;
          nb = (seq < packet_count) ? seq : packet_count;
          if (nb <= base) return;
          elapsed   = '0;
          old_limit = limit;
          nl = {1'b0, limit} + {1'b0, nb - base};
          if (nl > {1'b0, packet_count}) nl = {1'b0, packet_count};
          if (nl < {1'b0, nb}) nl = {1'b0, nb};
          base  = nb;
          limit = nl[31:0];
          if (nb >= packet_count) begin
            phase = PH_END;
            queue_send(KIND_END, session_seq);
          end else begin
            queue_range((old_limit > nb) ? old_limit : nb, limit);
          end
        end
        PH_END: begin
          if (seq != session_seq) return;
          elapsed = '0;
          phase   = PH_DONE;
          queue_send(KIND_DONE, session_seq);
        end
        default: ;
      endcase
    endfunction

    function void take_tick();
      logic [19:0] lim;
      if (phase != PH_START && phase != PH_DATA && phase != PH_END) return;
      elapsed = elapsed + 1'b1;
      lim = (timeout_ticks == '0) ? 20'd1 : timeout_ticks;
      if (elapsed < lim) return;
      elapsed = '0;
      case (phase)
        PH_START: queue_send(KIND_START, session_seq);
        PH_END:   queue_send(KIND_END, session_seq);
        default:  queue_range(base, limit);
      endcase
    endfunction

    // Runs one accepted input and returns how many sends it caused.
    function int note_input(logic [1:0] opc, logic [1:0] kind, logic [31:0] seq,
                            logic [31:0] chk);
      logic [31:0] w;
      batch.delete();
      case (opc)
        OPC_BEGIN: begin
          w       = span_width();
          base    = '0;
          limit   = (w < packet_count) ? w : packet_count;
          elapsed = '0;
          phase   = PH_START;
          queue_send(KIND_START, session_seq);
        end
        OPC_ACK:  if (kind == HDR_ACK && chk == '0) take_ack(seq);
        OPC_TICK: take_tick();
        default: ;
      endcase
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) pending.insert(pending.size(), batch[i]);
      return batch.size();
    endfunction

    // Returns an empty string on a match, else a description of the fault.
    function string check_send(logic [1:0] kind, logic [31:0] seq, logic last);
      send_rec_t want;
      if (pending.size() == 0)
        return $sformatf("unexpected send kind %0d seq %0d last %0d", kind, seq, last);
      want = pending.pop_front();
      if (kind !== want.kind || seq !== want.seq || last !== want.last)
        return $sformatf("send kind %0d seq %0d last %0d, wanted kind %0d seq %0d last %0d",
                         kind, seq, last, want.kind, want.seq, want.last);
      return "";
    endfunction
  endclass

  // Every input of the block starts at a known value.
  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [3:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata  = '0;    // [31:0] ack_seq, [63:32] ack_check
  logic [3:0]  s_tuser  = '0;    // [1:0] opcode, [3:2] ack_kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;          // [31:0] send_seq
  logic [1:0]  m_tuser;          // [1:0] send_kind
  logic        m_tlast;

  // Idling is switched off on both sides for one whole stretch of the run.
  logic        no_idling    = 1'b0;
  // Set once by the stimulus; the receiver then stalls for one long hold-off.
  logic        hold_off_req = 1'b0;

  int unsigned     mismatch_count = 0;
  transfer_tracker book = new();

  sliding_window_sender dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  // One register write: a setup cycle, then the access cycle. The register
  // takes the value at the edge where psel, penable and pready are high.
  // The bus is then left idle so that back-to-back writes never lower and
  // raise psel in the same step.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    book.set_register(idx, value);
  endtask

  task automatic load_settings(input logic [6:0] win, input logic [31:0] count,
                               input logic [31:0] sess, input logic [19:0] ticks);
    write_reg(REG_MAX_INFLIGHT, {25'b0, win});
    write_reg(REG_PACKET_COUNT, count);
    write_reg(REG_SESSION_SEQ, sess);
    write_reg(REG_TIMEOUT_TICKS, {12'b0, ticks});
  endtask

  // Offers one input transaction and waits for the block to take it. A
  // random gap may come first; s_tvalid is otherwise held high across
  // consecutive transactions. The tracker is updated at the accepting edge.
  task automatic send_item(input logic [1:0] opc, input logic [1:0] kind,
                           input logic [31:0] seq, input logic [31:0] chk);
    if (!no_idling && $urandom_range(99) < 6) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= {kind, opc};
    s_tdata  <= {chk, seq};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    void'(book.note_input(opc, kind, seq, chk));
  endtask

  task automatic send_ack(input logic [31:0] seq);
    send_item(OPC_ACK, HDR_ACK, seq, 32'd0);
  endtask

  task automatic send_tick();
    send_item(OPC_TICK, 2'd0, $urandom, $urandom);
  endtask

  task automatic send_begin();
    send_item(OPC_BEGIN, 2'($urandom_range(3)), $urandom, $urandom);
  endtask

  // Waits until every expected send has come out, then gives the sequencer
  // time to finish an input that causes no send, so that the block is idle.
  task automatic drain_and_pause();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (book.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random settings lean towards short transfers and short timeouts, with
  // the extremes of every register mixed in.
  task automatic load_random_settings();
    logic [6:0]  win;
    logic [31:0] count;
    logic [31:0] sess;
    logic [19:0] ticks;
    case ($urandom_range(5))
      0:       win = 7'd1;
      1:       win = 7'd64;
      2:       win = 7'($urandom_range(2, 8));
      3:       win = 7'($urandom_range(0, 127));
      default: win = 7'($urandom_range(1, 16));
    endcase
    case ($urandom_range(9))
      0:       count = 32'd0;
      1:       count = 32'hFFFF_FFFF - $urandom_range(0, 300);
      2:       count = $urandom_range(65, 300);
      default: count = $urandom_range(1, 40);
    endcase
    case ($urandom_range(5))
      0:       sess = $urandom;
      1:       sess = 32'hFFFF_FFFF;
      default: sess = count + $urandom_range(0, 1000);
    endcase
    case ($urandom_range(7))
      0:       ticks = 20'd0;
      1:       ticks = 20'hF_FFFF;
      2:       ticks = 20'($urandom_range(7, 40));
      default: ticks = 20'($urandom_range(1, 6));
    endcase
    load_settings(win, count, sess, ticks);
  endtask

  // Mostly acks that a real receiver would send for the current phase, so
  // that transfers run through to the end; the rest are ticks, duplicates,
  // acks past the end, and malformed headers with random content.
  task automatic random_item();
    int unsigned r;
    int unsigned gap;
    logic [31:0] seq;
    r = $urandom_range(99);
    if (r < 7) begin
      send_item(2'($urandom_range(3)), 2'($urandom_range(3)), $urandom,
                ($urandom_range(3) == 0) ? 32'd0 : $urandom);
    end else if (r < 22) begin
      send_tick();
    end else begin
      case (book.phase)
        PH_START: send_ack(($urandom_range(9) == 0) ? book.session_seq + 1
                                                    : book.session_seq);
        PH_DATA: begin
          gap = book.limit - book.base;
          if (gap == 0) gap = 1;
          r = $urandom_range(99);
          if (r < 70)      seq = book.base + $urandom_range(1, gap);
          else if (r < 80) seq = book.base - $urandom_range(0, 3);
          else if (r < 88) seq = book.packet_count + $urandom_range(0, 50);
          else if (r < 95) seq = book.base + $urandom_range(1, 200);
          else             seq = $urandom;
          send_ack(seq);
        end
        PH_END: send_ack(($urandom_range(7) == 0) ? $urandom : book.session_seq);
        default: send_begin();
      endcase
    end
  endtask

  // Receiver: ready most of the time, with random stalls, and one long
  // hold-off on request that it counts out itself.
  initial begin : receiver
    int unsigned held;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req <= 1'b0;
        m_tready     <= 1'b0;
        for (held = 1; held < HOLD_CYCLES; held++) @(posedge clk);
      end else if (!no_idling && $urandom_range(99) < 6) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Every output transaction is checked against the oldest expected send.
  always @(posedge clk) begin : watch_sends
    string msg;
    if (!rst && m_tvalid && m_tready) begin
      msg = book.check_send(m_tuser, m_tdata, m_tlast);
      if (msg != "") report_mismatch(msg);
    end
  end

  initial begin : stimulus
    int unsigned stretch;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    drain_and_pause();

    // Register reset values: an empty transfer goes from START straight to
    // END. Malformed and mismatched acks, a tick far from the timeout and
    // the unused opcode all pass without a send.
    send_begin();
    send_tick();
    send_item(OPC_ACK, 2'd0, 32'd0, 32'd0);
    send_item(OPC_ACK, HDR_ACK, 32'd0, 32'hFFFF_FFFF);
    send_ack(32'd1);
    send_item(OPC_UNUSED, HDR_ACK, 32'd0, 32'd0);
    send_ack(32'd0);
    send_ack(32'd0);
    drain_and_pause();

    // Oversized window register (clamped to 64), top session number and a
    // zero timeout that acts as one tick. The receiver holds off while a
    // full window goes out, so the block backs up and stalls its input.
    load_settings(7'd127, 32'd200, 32'hFFFF_FFFF, 20'd0);
    send_tick();
    send_begin();
    send_tick();
    hold_off_req <= 1'b1;
    send_ack(32'hFFFF_FFFF);
    send_ack(32'd0);
    send_ack(32'hFFFF_FFFF);
    send_tick();
    send_ack(32'd100);
    send_ack(32'hFFFF_FFFE);
    send_tick();
    send_begin();
    drain_and_pause();

    // Zero window register (used as one) and an empty transfer that gets a
    // packet count while waiting for the START ack: the data window stays
    // empty, so neither a timeout nor a small ack sends anything, until an
    // ack past the end is clamped and the END handshake closes it.
    load_settings(7'd0, 32'd0, 32'd5, 20'd1);
    send_begin();
    drain_and_pause();
    write_reg(REG_PACKET_COUNT, 32'd3);
    send_ack(32'd5);
    send_tick();
    send_ack(32'd2);
    send_ack(32'd9);
    send_ack(32'd5);
    drain_and_pause();

    // Random part: fresh settings between stretches of transfer traffic.
    stretch = 0;
    while (stretch * STRETCH_ITEMS < RANDOM_ITEMS) begin
      load_random_settings();
      no_idling = (stretch == 1);
      repeat (STRETCH_ITEMS) random_item();
      drain_and_pause();
      stretch++;
    end
    no_idling = 1'b0;

    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/sws_pkg.sv
hw/rtl/sws_seq.sv
hw/rtl/sliding_window_sender.sv
sim/sliding_window_sender_test.sv
